// File: src/sscc_pkg.sv
`default_nettype none

package sscc_pkg;

    // default sizes
    localparam int DEF_MAX_STATES    = 64;
    localparam int DEF_MAX_MOLECULES = 16;
    localparam int DEF_CONC_BITS     = 32;

    // fixed field widths
    localparam int SEP_W     = 64;
    localparam int NUM_MOL_W = 5;
    localparam int CFG_IDX_W = 1;
    localparam int TYPE_W    = 3;
    localparam int CONC_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int MATCH_W   = 6;
    localparam int COUNT_W   = 7;
    localparam int CLASS_W   = 7;

    // register reset values (threshold is 1.0e-4 in q32.32)
    localparam logic [SEP_W-1:0]     SEP_RESET     = 64'd429497;
    localparam logic [NUM_MOL_W-1:0] NUM_MOL_RESET = 5'd1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEP     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_MOL = 1'b1;

    // actions
    localparam logic ACT_CLEAR = 1'b0;
    localparam logic ACT_ELEM  = 1'b1;

    // stability types that are counted
    localparam int NUM_TYPES = 6;
    localparam logic [TYPE_W-1:0] TYPE_STABLE = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_SADDLE = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_OSC    = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_ZERO   = 3'd4;
    localparam logic [TYPE_W-1:0] TYPE_OTHER  = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_NEW  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

    // classification codes
    localparam int CODE_OSC          = 0;
    localparam int CODE_SINGLE       = 1;
    localparam int CODE_ILL          = 8;
    localparam int CODE_OSC_STABLE   = 9;
    localparam int OSC_STABLE_STATES = 3;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_tag;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_COPY,
        ST_FIN,
        ST_RESULT
    } t_state;

endpackage

`default_nettype wire

// File: src/sscc_ram.sv
`default_nettype none

module sscc_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: src/sscc_dist.sv
`default_nettype none

module sscc_dist #(
    parameter int CONC_BITS = 32,
    parameter int IW        = 6
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_flush,
    input  wire sscc_pkg::t_tag       i_tag,
    input  wire logic [IW-1:0]        i_idx,
    input  wire logic [CONC_BITS-1:0] i_a,
    input  wire logic [CONC_BITS-1:0] i_b,
    output sscc_pkg::t_tag            o_tag,
    output logic [IW-1:0]             o_idx,
    output logic [sscc_pkg::SEP_W-1:0] o_sum
);

    localparam int SQ_W = 2 * CONC_BITS;

    // stage a lines up with the memory read data
    sscc_pkg::t_tag r_tag_a, r_tag_b, r_tag_c;
    logic [IW-1:0]  r_idx_a, r_idx_b, r_idx_c;
    logic [SQ_W-1:0] r_sq;
    logic [sscc_pkg::SEP_W-1:0] r_acc;

    logic [CONC_BITS-1:0]       w_diff;
    logic [sscc_pkg::SEP_W-1:0] w_sq_ext;
    logic [sscc_pkg::SEP_W:0]   w_add;
    logic [sscc_pkg::SEP_W-1:0] n_acc;

    always_comb begin
        w_diff   = (i_a > i_b) ? (i_a - i_b) : (i_b - i_a);
        w_sq_ext = sscc_pkg::SEP_W'(r_sq);
        w_add    = {1'b0, r_acc} + {1'b0, w_sq_ext};
        if (r_tag_b.first) begin
            n_acc = w_sq_ext;
        end else if (w_add[sscc_pkg::SEP_W]) begin
            n_acc = '1;
        end else begin
            n_acc = w_add[sscc_pkg::SEP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_tag_a <= '0;
            r_tag_b <= '0;
            r_tag_c <= '0;
        end else begin
            r_tag_a <= i_tag;
            r_tag_b <= r_tag_a;
            r_tag_c <= r_tag_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx_a <= i_idx;
        r_idx_b <= r_idx_a;
        r_idx_c <= r_idx_b;
        r_sq    <= w_diff * w_diff;
        if (r_tag_b.valid) begin
            r_acc <= n_acc;
        end
    end

    assign o_tag = r_tag_c;
    assign o_idx = r_idx_c;
    assign o_sum = r_acc;

endmodule

`default_nettype wire

// File: src/steady_state_catalog_classifier_unit.sv
`default_nettype none

// Steady-state catalog classifier. Concentration elements arrive one per
// transfer on start/busy; a non-final element is taken while busy stays
// low. The final element of a vector starts a scan that streams every
// stored vector through a single read port of the catalog memory, one
// element per cycle, into a diff-square-accumulate pipeline. The scan ends
// at once on an empty catalog, and a duplicate ends it early and goes
// straight to the result cycle; storing a new vector copies it from the
// partial-vector buffer in the copy state; the decide and result states
// decide and present the result. The result is on the outputs for
// exactly one cycle with o_valid high and cannot be held off. A clear
// (action 0) is taken while idle and gives no result. Configuration is
// written through a plain write port and must only change while busy is
// low.
module steady_state_catalog_classifier_unit #(
    parameter int MAX_STATES    = sscc_pkg::DEF_MAX_STATES,
    parameter int MAX_MOLECULES = sscc_pkg::DEF_MAX_MOLECULES,
    parameter int CONC_BITS     = sscc_pkg::DEF_CONC_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // item transfer
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             i_action,
    input  wire logic [sscc_pkg::TYPE_W-1:0]      i_state_type,
    input  wire logic [sscc_pkg::CONC_W-1:0]      i_conc,
    // configuration
    input  wire logic                             i_cfg_we,
    input  wire logic [sscc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [sscc_pkg::SEP_W-1:0]       i_cfg_data,
    // result
    output logic                                  o_valid,
    output logic [sscc_pkg::STATUS_W-1:0]         o_status,
    output logic [sscc_pkg::MATCH_W-1:0]          o_match_index,
    output logic [sscc_pkg::COUNT_W-1:0]          o_stored_count,
    output logic [sscc_pkg::CLASS_W-1:0]          o_classification
);

    // state index, stored count, element index and element count widths
    localparam int IW    = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
    localparam int SW    = $clog2(MAX_STATES + 1);
    localparam int JW    = (MAX_MOLECULES > 1) ? $clog2(MAX_MOLECULES) : 1;
    localparam int CW    = $clog2(MAX_MOLECULES + 1);
    localparam int DEPTH = MAX_STATES * MAX_MOLECULES;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = AW + 1;

    sscc_pkg::t_state r_state, n_state;

    // configuration registers
    logic [sscc_pkg::SEP_W-1:0]     r_sep;
    logic [sscc_pkg::NUM_MOL_W-1:0] r_nm;

    // catalog bookkeeping
    logic [SW-1:0] r_stored;
    logic [BW-1:0] r_wbase;            // stored * MAX_MOLECULES
    logic [JW-1:0] r_pos;              // next element slot of the partial vector
    logic [SW-1:0] r_tcnt [sscc_pkg::NUM_TYPES];

    // scan and copy counters
    logic [SW-1:0] r_is;
    logic [JW-1:0] r_ij;
    logic [BW-1:0] r_base;
    logic [JW-1:0] r_cj;
    logic [JW-1:0] r_cp_j;
    logic          r_cp_v;

    // result payload
    logic [sscc_pkg::TYPE_W-1:0]   r_type;
    logic [sscc_pkg::STATUS_W-1:0] r_status;
    logic [IW-1:0]                 r_match;

    logic [CW-1:0] w_count;
    logic          w_accept;
    logic          w_last_elem;
    logic          w_ij_last;
    logic          w_cj_last;
    logic          w_issue;
    logic          w_full;
    logic          w_hit;
    logic          w_scan_end;
    logic          w_flush;

    sscc_pkg::t_tag        w_tag;
    sscc_pkg::t_tag        w_dtag;
    logic [IW-1:0]         w_didx;
    logic [sscc_pkg::SEP_W-1:0] w_sum;

    logic [CONC_BITS-1:0] w_cat_rdata;
    logic [CONC_BITS-1:0] w_pend_rdata;
    logic [AW-1:0]        w_cat_raddr;
    logic [AW-1:0]        w_cat_waddr;
    logic [JW-1:0]        w_pend_raddr;
    logic                 w_pend_we;

    // classification terms
    logic [31:0] w_n, w_stable, w_saddle, w_osc, w_zo, w_code;

    // ------------------------------------------------------------------
    // element count in effect: zero acts as one, clamp to the buffer size
    // ------------------------------------------------------------------
    always_comb begin
        if (r_nm == '0) begin
            w_count = CW'(1);
        end else if (32'(r_nm) > MAX_MOLECULES) begin
            w_count = CW'(MAX_MOLECULES);
        end else begin
            w_count = CW'(r_nm);
        end
    end

    assign w_accept    = start && !busy;
    assign w_last_elem = (32'(r_pos) + 32'd1) >= 32'(w_count);
    assign w_ij_last   = (32'(r_ij) + 32'd1) == 32'(w_count);
    assign w_cj_last   = (32'(r_cj) + 32'd1) == 32'(w_count);
    assign w_full      = 32'(r_stored) >= MAX_STATES;

    // ------------------------------------------------------------------
    // scan: one catalog element per cycle, tagged with its state index
    // ------------------------------------------------------------------
    assign w_issue     = (r_state == sscc_pkg::ST_SCAN) && (r_is < r_stored);
    assign w_tag.valid = w_issue;
    assign w_tag.first = (r_ij == '0);
    assign w_tag.last  = w_ij_last;
    assign w_flush     = (r_state != sscc_pkg::ST_SCAN);

    assign w_cat_raddr  = AW'(r_base + BW'(r_ij));
    assign w_cat_waddr  = AW'(r_wbase + BW'(r_cp_j));
    assign w_pend_raddr = (r_state == sscc_pkg::ST_COPY) ? r_cj : r_ij;
    assign w_pend_we    = w_accept && (i_action == sscc_pkg::ACT_ELEM);

    // first similar entry wins since entries leave the pipeline in order;
    // a saturated sum is all ones and never passes the compare
    assign w_hit      = w_dtag.valid && w_dtag.last && (w_sum < r_sep);
    assign w_scan_end = w_dtag.valid && w_dtag.last &&
                        ((32'(w_didx) + 32'd1) == 32'(r_stored));

    // catalog of stored vectors, MAX_MOLECULES slots per state
    sscc_ram #(
        .WIDTH (CONC_BITS),
        .DEPTH (DEPTH)
    ) u_catalog (
        .i_clk   (i_clk),
        .i_we    (r_cp_v),
        .i_waddr (w_cat_waddr),
        .i_wdata (w_pend_rdata),
        .i_raddr (w_cat_raddr),
        .o_rdata (w_cat_rdata)
    );

    // partial vector being assembled
    sscc_ram #(
        .WIDTH (CONC_BITS),
        .DEPTH (MAX_MOLECULES)
    ) u_pending (
        .i_clk   (i_clk),
        .i_we    (w_pend_we),
        .i_waddr (r_pos),
        .i_wdata (i_conc[CONC_BITS-1:0]),
        .i_raddr (w_pend_raddr),
        .o_rdata (w_pend_rdata)
    );

    sscc_dist #(
        .CONC_BITS (CONC_BITS),
        .IW        (IW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flush (w_flush),
        .i_tag   (w_tag),
        .i_idx   (IW'(r_is)),
        .i_a     (w_cat_rdata),
        .i_b     (w_pend_rdata),
        .o_tag   (w_dtag),
        .o_idx   (w_didx),
        .o_sum   (w_sum)
    );

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sscc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        busy    = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            sscc_pkg::ST_IDLE: begin
                busy = 1'b0;
                if (start && (i_action == sscc_pkg::ACT_ELEM) && w_last_elem) begin
                    n_state = sscc_pkg::ST_SCAN;
                end
            end
            sscc_pkg::ST_SCAN: begin
                if (r_stored == '0) begin
                    n_state = sscc_pkg::ST_DECIDE;
                end else if (w_hit) begin
                    n_state = sscc_pkg::ST_RESULT;
                end else if (w_scan_end) begin
                    n_state = sscc_pkg::ST_DECIDE;
                end
            end
            sscc_pkg::ST_DECIDE: begin
                n_state = w_full ? sscc_pkg::ST_RESULT : sscc_pkg::ST_COPY;
            end
            sscc_pkg::ST_COPY: begin
                if (w_cj_last) begin
                    n_state = sscc_pkg::ST_FIN;
                end
            end
            sscc_pkg::ST_FIN: begin
                n_state = sscc_pkg::ST_RESULT;
            end
            sscc_pkg::ST_RESULT: begin
                o_valid = 1'b1;
                n_state = sscc_pkg::ST_IDLE;
            end
            default: begin
                n_state = sscc_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep    <= sscc_pkg::SEP_RESET;
            r_nm     <= sscc_pkg::NUM_MOL_RESET;
            r_stored <= '0;
            r_wbase  <= '0;
            r_pos    <= '0;
            r_cp_v   <= 1'b0;
            for (int t = 0; t < sscc_pkg::NUM_TYPES; t++) begin
                r_tcnt[t] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sscc_pkg::CFG_SEP:     r_sep <= i_cfg_data;
                    sscc_pkg::CFG_NUM_MOL: r_nm  <= i_cfg_data[sscc_pkg::NUM_MOL_W-1:0];
                    default: ;
                endcase
            end

            if (w_accept) begin
                if (i_action == sscc_pkg::ACT_CLEAR) begin
                    r_stored <= '0;
                    r_wbase  <= '0;
                    r_pos    <= '0;
                    for (int t = 0; t < sscc_pkg::NUM_TYPES; t++) begin
                        r_tcnt[t] <= '0;
                    end
                end else if (w_last_elem) begin
                    r_pos <= '0;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end

            // write of the copied element lands in the cycle after its read
            r_cp_v <= (r_state == sscc_pkg::ST_COPY);

            if (r_state == sscc_pkg::ST_FIN) begin
                r_stored <= r_stored + 1'b1;
                r_wbase  <= r_wbase + BW'(MAX_MOLECULES);
                if (32'(r_type) < sscc_pkg::NUM_TYPES) begin
                    r_tcnt[r_type] <= r_tcnt[r_type] + 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // counters and result payload
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_type <= i_state_type;
            r_is   <= '0;
            r_ij   <= '0;
            r_base <= '0;
        end

        if (w_issue) begin
            if (w_ij_last) begin
                r_ij   <= '0;
                r_is   <= r_is + 1'b1;
                r_base <= r_base + BW'(MAX_MOLECULES);
            end else begin
                r_ij <= r_ij + 1'b1;
            end
        end

        if (r_state == sscc_pkg::ST_DECIDE) begin
            r_cj <= '0;
        end else if (r_state == sscc_pkg::ST_COPY) begin
            r_cj <= r_cj + 1'b1;
        end
        r_cp_j <= r_cj;

        if ((r_state == sscc_pkg::ST_SCAN) && (r_stored != '0) && w_hit) begin
            r_status <= sscc_pkg::STAT_DUP;
            r_match  <= w_didx;
        end else if ((r_state == sscc_pkg::ST_DECIDE) && w_full) begin
            r_status <= sscc_pkg::STAT_FULL;
            r_match  <= '0;
        end else if (r_state == sscc_pkg::ST_FIN) begin
            r_status <= sscc_pkg::STAT_NEW;
            r_match  <= '0;
        end
    end

    // ------------------------------------------------------------------
    // system classification from the per-type counts
    // ------------------------------------------------------------------
    always_comb begin
        w_n      = 32'(r_stored);
        w_stable = 32'(r_tcnt[sscc_pkg::TYPE_STABLE]);
        w_saddle = 32'(r_tcnt[sscc_pkg::TYPE_SADDLE]);
        w_osc    = 32'(r_tcnt[sscc_pkg::TYPE_OSC]);
        w_zo     = 32'(r_tcnt[sscc_pkg::TYPE_ZERO]) + 32'(r_tcnt[sscc_pkg::TYPE_OTHER]);
        w_code   = w_stable;
        if (w_n == w_zo) begin
            w_code = sscc_pkg::CODE_SINGLE;
        end
        // single saddle or oscillation alone
        if ((w_n == 32'd1) && ((w_saddle == 32'd1) || (w_osc == 32'd1))) begin
            w_code = sscc_pkg::CODE_OSC;
        end else if ((w_n >= 32'd1) && (w_stable == 32'd0) && (w_n != w_zo)) begin
            w_code = sscc_pkg::CODE_ILL;
        end
        // oscillation beside one stable state
        if ((w_n == sscc_pkg::OSC_STABLE_STATES) && (w_osc == 32'd1) &&
            (w_stable == 32'd1)) begin
            w_code = sscc_pkg::CODE_OSC_STABLE;
        end
    end

    assign o_status         = r_status;
    assign o_match_index    = sscc_pkg::MATCH_W'(r_match);
    assign o_stored_count   = sscc_pkg::COUNT_W'(r_stored);
    assign o_classification = w_code[sscc_pkg::CLASS_W-1:0];

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_result_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_store_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == sscc_pkg::STAT_NEW)) |->
            (r_stored == SW'($past(r_stored) + 1'b1)))
        else $error("new vector reported without catalog growth");

    a_catalog_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_stored) <= MAX_STATES)
        else $error("catalog count beyond capacity");

    a_copy_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_v |-> ((r_state == sscc_pkg::ST_COPY) || (r_state == sscc_pkg::ST_FIN)))
        else $error("catalog write outside copy");

endmodule

`default_nettype wire
